[design/cdem_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cdem_pkg - chain domain energy minimizer shared definitions
// Word types, register codes and reset values, and the request and response
// structs that run between the sequencer and the shared arithmetic units.
// ----------------------------------------------------------------------------
package cdem_pkg;

	localparam int unsigned CFG_W     = 40;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_FOLDED_LENGTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UNFOLD_RATIO   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_TOLERANCE = 2'd2;

	localparam logic [39:0] FOLDED_LENGTH_RST  = 40'd15461882266;
	localparam logic [39:0] UNFOLD_RATIO_RST   = 40'd32641751450;
	localparam logic [31:0] STEP_TOLERANCE_RST = 32'd43;

	localparam logic [63:0] SAT        = 64'h4000_0000_0000_0000;
	localparam logic [63:0] TWO_PI_Q59 = 64'h3243_F6A8_885A_308D;

	typedef struct packed {
		logic [39:0] folded_length;
		logic [39:0] unfold_ratio;
		logic [31:0] step_tolerance;
	} cfg_t;

	typedef struct packed {
		logic        start;
		logic        sh59;
		logic [63:0] a;
		logic [63:0] b;
	} mul_req_t;

	typedef struct packed {
		logic        start;
		logic [63:0] num_hi;
		logic [63:0] num_lo;
		logic [63:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] res;
	} unit_rsp_t;

endpackage
`default_nettype wire

[design/cdem_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cdem_in_if / cdem_out_if - word channels
// Valid/ready channels carrying one input word and one result word.
// ----------------------------------------------------------------------------
interface cdem_in_if;
	logic        valid;
	logic        ready;
	logic [39:0] force_req;
	logic [39:0] delta_e;

	modport source(output valid, force_req, delta_e, input ready);
	modport sink(input valid, force_req, delta_e, output ready);
endinterface

interface cdem_out_if;
	logic               valid;
	logic               ready;
	logic        [31:0] extension_ratio;
	logic        [32:0] unfolded_fraction;
	logic        [39:0] end_to_end_distance;
	logic signed [47:0] min_free_energy;

	modport source(output valid, extension_ratio, unfolded_fraction, end_to_end_distance,
		min_free_energy, input ready);
	modport sink(input valid, extension_ratio, unfolded_fraction, end_to_end_distance,
		min_free_energy, output ready);
endinterface
`default_nettype wire

[design/cdem_mul.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cdem_mul - shared fixed-point multiplier
// 64x64 product from four 32x32 partial products, one per cycle, then a
// right shift by the fraction width or by 59 with saturation at 2^62.
// ----------------------------------------------------------------------------
module cdem_mul import cdem_pkg::*; #(
	parameter int unsigned FRACTION_BITS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  mul_req_t  req,
	output unit_rsp_t rsp
);

	logic [63:0]  a_q, b_q, res_q;
	logic         sh59_q;
	logic [127:0] acc_q;
	logic [1:0]   cnt_q;
	logic         busy_q, fin_q, done_q;

	logic [63:0]  pp;
	logic [1:0]   pos;
	logic [127:0] pp_sh, shifted;
	logic [63:0]  sat_res;

	always_comb begin
		pp      = 64'(a_q[{cnt_q[1], 5'd0} +: 32]) * 64'(b_q[{cnt_q[0], 5'd0} +: 32]);
		pos     = {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
		pp_sh   = 128'(pp) << {pos, 5'd0};
		shifted = sh59_q ? (acc_q >> 59) : (acc_q >> FRACTION_BITS);
		sat_res = (shifted > {64'd0, SAT}) ? SAT : shifted[63:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 2'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q    <= req.a;
			b_q    <= req.b;
			sh59_q <= req.sh59;
			acc_q  <= 128'd0;
		end else if (busy_q) begin
			acc_q <= acc_q + pp_sh;
		end else if (fin_q) begin
			res_q <= sat_res;
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = res_q;

endmodule
`default_nettype wire

[design/cdem_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cdem_div - shared restoring divider
// 128 by 64 bit division, one quotient bit per cycle, 64 quotient bits in all.
// Divide by zero or a quotient beyond 64 bits gives 2^62; results clamp there.
// ----------------------------------------------------------------------------
module cdem_div import cdem_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  div_req_t  req,
	output unit_rsp_t rsp
);

	logic [63:0] rem_q, lo_q, q_q, den_q, res_q;
	logic        sat_q;
	logic [5:0]  cnt_q;
	logic        busy_q, fin_q, done_q;

	logic [64:0] rem2;
	logic        ge;
	logic [64:0] diff;
	logic        ovf;

	always_comb begin
		rem2 = {rem_q, lo_q[63]};
		ge   = rem2 >= {1'b0, den_q};
		diff = rem2 - {1'b0, den_q};
		ovf  = (req.den == 64'd0) || (req.num_hi >= req.den);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 6'd0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= !ovf;
				fin_q  <= ovf;
				cnt_q  <= 6'd63;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num_hi;
			lo_q  <= req.num_lo;
			den_q <= req.den;
			q_q   <= 64'd0;
			sat_q <= ovf;
		end else if (busy_q) begin
			rem_q <= ge ? diff[63:0] : rem2[63:0];
			lo_q  <= {lo_q[62:0], 1'b0};
			q_q   <= {q_q[62:0], ge};
		end else if (fin_q) begin
			res_q <= (sat_q || (q_q > SAT)) ? SAT : q_q;
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = res_q;

endmodule
`default_nettype wire

[design/cdem_seq.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cdem_seq - minimizer sequencer
// Runs the extension bisection, the grid search over the unfolded fraction
// with its cosine series, and the final distance, on the shared multiplier
// and divider. Holds the result word until it is taken.
// ----------------------------------------------------------------------------
module cdem_seq import cdem_pkg::*; #(
	parameter int unsigned GRID_POINTS   = 20,
	parameter int unsigned FRACTION_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	cdem_in_if.sink           in_ch,
	cdem_out_if.source        out_ch,
	output mul_req_t          mul_req,
	input  unit_rsp_t         mul_rsp,
	output div_req_t          div_req,
	input  unit_rsp_t         div_rsp
);

	localparam int unsigned FB      = FRACTION_BITS;
	localparam int unsigned LSH     = (FB >= 32) ? FB - 32 : 0;
	localparam int unsigned RSH     = (FB < 32) ? 32 - FB : 0;
	localparam int unsigned DIVS    = (GRID_POINTS > 1) ? GRID_POINTS - 1 : 1;
	localparam int unsigned PIW     = $clog2(GRID_POINTS + 1);
	localparam logic [63:0] ONE     = 64'd1 << FB;
	localparam logic [63:0] QUARTER = ONE >> 2;
	localparam logic [63:0] C99     = (ONE * 64'd99) / 64'd100;
	localparam logic [63:0] C999    = (ONE * 64'd999) / 64'd1000;
	localparam logic [63:0] STEP0   = ONE / 64'(DIVS);
	localparam logic [63:0] RECIP_DIVS = ((64'd1 << 59) + 64'(DIVS) - 64'd1) / 64'(DIVS);
	localparam logic [63:0] RECIP_TEN  = ((64'd1 << 59) + 64'd9) / 64'd10;
	localparam logic [6:0]  BIS_MAX = 7'd100;
	localparam logic [4:0]  SER_MAX = 5'd20;

	typedef enum logic [29:0] {
		S_IDLE   = 30'h0000_0001,
		S_WAIT   = 30'h0000_0002,
		S_XU_R   = 30'h0000_0004,
		S_BIS    = 30'h0000_0008,
		S_MS_DIV = 30'h0000_0010,
		S_MS_SQ  = 30'h0000_0020,
		S_MS_V   = 30'h0000_0040,
		S_G_X2   = 30'h0000_0080,
		S_G_A    = 30'h0000_0100,
		S_G_DIV  = 30'h0000_0200,
		S_G_R    = 30'h0000_0400,
		S_FX_R   = 30'h0000_0800,
		S_STEP_R = 30'h0000_1000,
		S_PT     = 30'h0000_2000,
		S_PT_N   = 30'h0000_4000,
		S_PT_L   = 30'h0000_8000,
		S_PT_W   = 30'h0001_0000,
		S_TH     = 30'h0002_0000,
		S_TH2    = 30'h0004_0000,
		S_SER    = 30'h0008_0000,
		S_SER_M  = 30'h0010_0000,
		S_SER_D  = 30'h0020_0000,
		S_COS    = 30'h0040_0000,
		S_DN     = 30'h0080_0000,
		S_DC     = 30'h0100_0000,
		S_E      = 30'h0200_0000,
		S_PASS   = 30'h0400_0000,
		S_PASS_R = 30'h0800_0000,
		S_FIN    = 30'h1000_0000,
		S_OUT    = 30'h2000_0000
	} state_t;

	function automatic logic [63:0] in_q32(input logic [63:0] v);
		return (v << LSH) >> RSH;
	endfunction

	function automatic logic [63:0] mag(input logic signed [63:0] v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic signed [64:0] clamp65(input logic signed [64:0] v);
		logic signed [64:0] s;
		s = $signed({1'b0, SAT});
		if (v > s) return s;
		if (v < -s) return -s;
		return v;
	endfunction

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		s = clamp65($signed({a[63], a})) + clamp65($signed({b[63], b}));
		s = clamp65(s);
		return s[63:0];
	endfunction

	function automatic logic [63:0] out_q32(input logic [63:0] m, input logic [63:0] cap);
		logic [63:0] v;
		v = m >> LSH;
		if (RSH != 0) begin
			if (m > (cap >> RSH)) return cap;
			v = m << RSH;
		end
		return (v > cap) ? cap : v;
	endfunction

	state_t state_q, ret_q;
	mul_req_t mreq_q;
	div_req_t dreq_q;

	logic [63:0] f_q, de_q, xi_q, tol_q, lo_q, hi_q, mid_q, x_q, g_q, fx_q;
	logic [63:0] step_q, nlo_q, nhi_q, n_q, lu_q, th_q, th2_q, term_q, cmag_q, best_n_q;
	logic signed [63:0] dxi_q, wlc_q, sum_q, dn_q, u_q, best_e_q;
	logic [5:0] p_q;
	logic [4:0] k_q;
	logic [1:0] quad_q;
	logic       cneg_q, wlc_sat_q, have_q;
	logic [6:0] bis_q;
	logic [PIW-1:0] pt_q;

	logic        out_valid_q;
	logic [31:0] ext_q;
	logic [32:0] uf_q;
	logic [39:0] dist_q;
	logic [47:0] en_q;

	logic [63:0] hl, four_mid, msf, sm_l, lu_c, nlo_new, nhi_new, bsum, smc;
	logic signed [63:0] l_c, c_c, e_c;
	logic [11:0] ser_den;
	logic [63:0] ext_c, uf_c, dist_c, en_c, em;

	always_comb begin
		hl       = hi_q - lo_q;
		four_mid = mid_q << 2;
		if (mul_rsp.res > SAT - four_mid) msf = SAT;
		else msf = (mul_rsp.res - ONE + four_mid) >> 2;

		sm_l = dxi_q[63] ? 64'(-mul_rsp.res) : mul_rsp.res;
		l_c  = sat_add($signed(xi_q), $signed(sm_l));
		lu_c = l_c[63] ? 64'd0 : 64'(l_c);

		c_c     = ((quad_q == 2'd1) || (quad_q == 2'd2)) ? -sum_q : sum_q;
		ser_den = 12'(({6'd0, p_q} + 12'd1) * ({6'd0, p_q} + 12'd2));
		smc     = cneg_q ? mul_rsp.res : 64'(-mul_rsp.res);
		e_c     = sat_add(sat_add(wlc_q, u_q), -$signed(mul_rsp.res));

		nlo_new = (best_n_q > step_q) ? best_n_q - step_q : 64'd0;
		bsum    = best_n_q + step_q;
		nhi_new = (bsum > ONE) ? ONE : bsum;

		ext_c  = out_q32(x_q, 64'hFFFF_FFFF);
		uf_c   = out_q32(best_n_q, 64'h1_0000_0000);
		dist_c = out_q32(mul_rsp.res, 64'hFF_FFFF_FFFF);
		if (best_e_q[63]) begin
			em   = out_q32(mag(best_e_q), 64'h8000_0000_0000);
			en_c = 64'd0 - em;
		end else begin
			em   = 64'd0;
			en_c = out_q32(64'(best_e_q), 64'h7FFF_FFFF_FFFF);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			ret_q        <= S_IDLE;
			mreq_q.start <= 1'b0;
			dreq_q.start <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			mreq_q.start <= 1'b0;
			dreq_q.start <= 1'b0;
			if (out_ch.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_ch.valid) begin
					f_q          <= in_q32(64'(in_ch.force_req));
					de_q         <= in_q32(64'(in_ch.delta_e));
					xi_q         <= in_q32(64'(cfg.folded_length));
					tol_q        <= in_q32(64'(cfg.step_tolerance));
					mreq_q.start <= 1'b1;
					mreq_q.sh59  <= 1'b0;
					mreq_q.a     <= in_q32(64'(cfg.unfold_ratio));
					mreq_q.b     <= in_q32(64'(cfg.folded_length));
					ret_q        <= S_XU_R;
					state_q      <= S_WAIT;
				end
				S_WAIT: if (mul_rsp.done || div_rsp.done) state_q <= ret_q;
				S_XU_R: begin
					dxi_q <= $signed(mul_rsp.res) - $signed(xi_q);
					lo_q  <= 64'd0;
					hi_q  <= ONE;
					bis_q <= 7'd0;
					x_q   <= 64'd0;
					state_q <= (f_q != 64'd0) ? S_BIS : S_G_X2;
				end
				S_BIS: if ((bis_q < BIS_MAX) && (hl > 64'd1)) begin
					mid_q   <= lo_q + (hl >> 1);
					state_q <= S_MS_DIV;
				end else begin
					x_q     <= lo_q + (hl >> 1);
					state_q <= S_G_X2;
				end
				S_MS_DIV: if (mid_q >= C99) begin
					hi_q    <= mid_q;
					bis_q   <= bis_q + 7'd1;
					state_q <= S_BIS;
				end else begin
					dreq_q.start  <= 1'b1;
					dreq_q.num_hi <= ONE >> (64 - FB);
					dreq_q.num_lo <= ONE << FB;
					dreq_q.den    <= ONE - mid_q;
					ret_q         <= S_MS_SQ;
					state_q       <= S_WAIT;
				end
				S_MS_SQ: begin
					mreq_q.start <= 1'b1;
					mreq_q.sh59  <= 1'b0;
					mreq_q.a     <= div_rsp.res;
					mreq_q.b     <= div_rsp.res;
					ret_q        <= S_MS_V;
					state_q      <= S_WAIT;
				end
				S_MS_V: begin
					if (msf < f_q) lo_q <= mid_q;
					else hi_q <= mid_q;
					bis_q   <= bis_q + 7'd1;
					state_q <= S_BIS;
				end
				S_G_X2: begin
					mreq_q.start <= 1'b1;
					mreq_q.sh59  <= 1'b0;
					state_q      <= S_WAIT;
					if (x_q >= C999) begin
						wlc_sat_q <= 1'b1;
						mreq_q.a  <= f_q;
						mreq_q.b  <= x_q;
						ret_q     <= S_FX_R;
					end else begin
						wlc_sat_q <= 1'b0;
						mreq_q.a  <= x_q;
						mreq_q.b  <= x_q;
						ret_q     <= S_G_A;
					end
				end
				S_G_A: begin
					mreq_q.start <= 1'b1;
					mreq_q.sh59  <= 1'b0;
					mreq_q.a     <= mul_rsp.res;
					mreq_q.b     <= 64'd3 * ONE - (x_q << 1);
					ret_q        <= S_G_DIV;
					state_q      <= S_WAIT;
				end
				S_G_DIV: begin
					dreq_q.start  <= 1'b1;
					dreq_q.num_hi <= mul_rsp.res >> (64 - FB);
					dreq_q.num_lo <= mul_rsp.res << FB;
					dreq_q.den    <= ONE - x_q;
					ret_q         <= S_G_R;
					state_q       <= S_WAIT;
				end
				S_G_R: begin
					g_q          <= div_rsp.res;
					mreq_q.start <= 1'b1;
					mreq_q.sh59  <= 1'b0;
					mreq_q.a     <= f_q;
					mreq_q.b     <= x_q;
					ret_q        <= S_FX_R;
					state_q      <= S_WAIT;
				end
				S_FX_R: begin
					fx_q    <= mul_rsp.res;
					state_q <= S_STEP_R;
				end
				S_STEP_R: begin
					step_q  <= STEP0;
					nlo_q   <= 64'd0;
					nhi_q   <= ONE;
					have_q  <= 1'b0;
					pt_q    <= '0;
					state_q <= S_PT;
				end
				S_PT: if (pt_q == PIW'(GRID_POINTS)) begin
					state_q <= S_PASS;
				end else begin
					mreq_q.start <= 1'b1;
					mreq_q.sh59  <= 1'b1;
					mreq_q.a     <= (nhi_q - nlo_q) * 64'(pt_q);
					mreq_q.b     <= RECIP_DIVS;
					ret_q        <= S_PT_N;
					state_q      <= S_WAIT;
				end
				S_PT_N: begin
					n_q          <= nlo_q + mul_rsp.res;
					mreq_q.start <= 1'b1;
					mreq_q.sh59  <= 1'b0;
					mreq_q.a     <= nlo_q + mul_rsp.res;
					mreq_q.b     <= mag(dxi_q);
					ret_q        <= S_PT_L;
					state_q      <= S_WAIT;
				end
				S_PT_L: begin
					lu_q <= lu_c;
					if (wlc_sat_q) begin
						state_q <= S_PT_W;
					end else begin
						mreq_q.start <= 1'b1;
						mreq_q.sh59  <= 1'b0;
						mreq_q.a     <= lu_c;
						mreq_q.b     <= g_q;
						ret_q        <= S_PT_W;
						state_q      <= S_WAIT;
					end
				end
				S_PT_W: begin
					wlc_q        <= wlc_sat_q ? $signed(SAT) : $signed(mul_rsp.res >> 2);
					quad_q       <= n_q[FB-1 -: 2];
					mreq_q.start <= 1'b1;
					mreq_q.sh59  <= 1'b1;
					mreq_q.a     <= n_q & (QUARTER - 64'd1);
					mreq_q.b     <= TWO_PI_Q59;
					ret_q        <= S_TH;
					state_q      <= S_WAIT;
				end
				S_TH: begin
					th_q         <= mul_rsp.res;
					mreq_q.start <= 1'b1;
					mreq_q.sh59  <= 1'b0;
					mreq_q.a     <= mul_rsp.res;
					mreq_q.b     <= mul_rsp.res;
					ret_q        <= S_TH2;
					state_q      <= S_WAIT;
				end
				S_TH2: begin
					th2_q   <= mul_rsp.res;
					term_q  <= quad_q[0] ? th_q : ONE;
					sum_q   <= quad_q[0] ? $signed(th_q) : $signed(ONE);
					p_q     <= quad_q[0] ? 6'd1 : 6'd0;
					k_q     <= 5'd0;
					state_q <= S_SER;
				end
				S_SER: if ((k_q < SER_MAX) && (term_q != 64'd0)) begin
					mreq_q.start <= 1'b1;
					mreq_q.sh59  <= 1'b0;
					mreq_q.a     <= term_q;
					mreq_q.b     <= th2_q;
					ret_q        <= S_SER_M;
					state_q      <= S_WAIT;
				end else begin
					state_q <= S_COS;
				end
				S_SER_M: begin
					dreq_q.start  <= 1'b1;
					dreq_q.num_hi <= 64'd0;
					dreq_q.num_lo <= mul_rsp.res;
					dreq_q.den    <= 64'(ser_den);
					ret_q         <= S_SER_D;
					state_q       <= S_WAIT;
				end
				S_SER_D: begin
					term_q  <= div_rsp.res;
					sum_q   <= k_q[0] ? sum_q + $signed(div_rsp.res)
						: sum_q - $signed(div_rsp.res);
					p_q     <= p_q + 6'd2;
					k_q     <= k_q + 5'd1;
					state_q <= S_SER;
				end
				S_COS: begin
					cneg_q       <= c_c[63];
					cmag_q       <= mag(c_c);
					mreq_q.start <= 1'b1;
					mreq_q.sh59  <= 1'b0;
					mreq_q.a     <= de_q;
					mreq_q.b     <= n_q;
					ret_q        <= S_DN;
					state_q      <= S_WAIT;
				end
				S_DN: begin
					dn_q         <= $signed(mul_rsp.res);
					mreq_q.start <= 1'b1;
					mreq_q.sh59  <= 1'b0;
					mreq_q.a     <= de_q;
					mreq_q.b     <= cmag_q;
					ret_q        <= S_DC;
					state_q      <= S_WAIT;
				end
				S_DC: begin
					u_q          <= sat_add(dn_q, $signed(smc));
					mreq_q.start <= 1'b1;
					mreq_q.sh59  <= 1'b0;
					mreq_q.a     <= fx_q;
					mreq_q.b     <= lu_q;
					ret_q        <= S_E;
					state_q      <= S_WAIT;
				end
				S_E: begin
					if (!have_q || (e_c < best_e_q)) begin
						best_e_q <= e_c;
						best_n_q <= n_q;
					end
					have_q  <= 1'b1;
					pt_q    <= pt_q + PIW'(1);
					state_q <= S_PT;
				end
				S_PASS: if (step_q <= tol_q) begin
					mreq_q.start <= 1'b1;
					mreq_q.sh59  <= 1'b0;
					mreq_q.a     <= best_n_q;
					mreq_q.b     <= mag(dxi_q);
					ret_q        <= S_FIN;
					state_q      <= S_WAIT;
				end else begin
					nlo_q        <= nlo_new;
					nhi_q        <= nhi_new;
					mreq_q.start <= 1'b1;
					mreq_q.sh59  <= 1'b1;
					mreq_q.a     <= nhi_new - nlo_new;
					mreq_q.b     <= RECIP_TEN;
					ret_q        <= S_PASS_R;
					state_q      <= S_WAIT;
				end
				S_PASS_R: begin
					step_q  <= mul_rsp.res;
					pt_q    <= '0;
					state_q <= S_PT;
				end
				S_FIN: begin
					mreq_q.start <= 1'b1;
					mreq_q.sh59  <= 1'b0;
					mreq_q.a     <= x_q;
					mreq_q.b     <= lu_c;
					ret_q        <= S_OUT;
					state_q      <= S_WAIT;
				end
				S_OUT: if (!out_valid_q || out_ch.ready) begin
					ext_q       <= ext_c[31:0];
					uf_q        <= uf_c[32:0];
					dist_q      <= dist_c[39:0];
					en_q        <= en_c[47:0];
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ch.ready                = (state_q == S_IDLE);
	assign out_ch.valid               = out_valid_q;
	assign out_ch.extension_ratio     = ext_q;
	assign out_ch.unfolded_fraction   = uf_q;
	assign out_ch.end_to_end_distance = dist_q;
	assign out_ch.min_free_energy     = $signed(en_q);
	assign mul_req                    = mreq_q;
	assign div_req                    = dreq_q;

endmodule
`default_nettype wire

[design/chain_domain_energy_minimizer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// chain_domain_energy_minimizer - top level
// Solves the chain extension from the pulling force, then grid-searches the
// unfolded fraction for the lowest domain free energy.
// ----------------------------------------------------------------------------
// One word is in flight at a time: in_ch.ready is high only while the
// sequencer is idle, and the finished word waits in the output register so a
// new word can be taken before it is read. The shared divider and multiplier
// set the latency. The bisection runs over FRACTION_BITS rounds; each grid
// point works through its cosine series (up to about ten terms, at most
// twenty) and the other work, GRID_POINTS points per pass and eleven passes
// at the default tolerance.
// Configuration takes effect at the next accepted word.
// ----------------------------------------------------------------------------
module chain_domain_energy_minimizer import cdem_pkg::*; #(
	parameter int unsigned GRID_POINTS   = 20,
	parameter int unsigned FRACTION_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	cdem_in_if.sink              in_ch,
	cdem_out_if.source           out_ch
);

	cfg_t      cfg_q;
	mul_req_t  mul_req;
	div_req_t  div_req;
	unit_rsp_t mul_rsp, div_rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.folded_length  <= FOLDED_LENGTH_RST;
			cfg_q.unfold_ratio   <= UNFOLD_RATIO_RST;
			cfg_q.step_tolerance <= STEP_TOLERANCE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FOLDED_LENGTH:  cfg_q.folded_length  <= cfg_data;
				REG_UNFOLD_RATIO:   cfg_q.unfold_ratio   <= cfg_data;
				REG_STEP_TOLERANCE: cfg_q.step_tolerance <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	cdem_mul #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mul_req),
		.rsp   (mul_rsp)
	);

	cdem_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	cdem_seq #(
		.GRID_POINTS  (GRID_POINTS),
		.FRACTION_BITS(FRACTION_BITS)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.mul_req(mul_req),
		.mul_rsp(mul_rsp),
		.div_req(div_req),
		.div_rsp(div_rsp)
	);

endmodule
`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - chain domain energy minimizer
// Drives force and unfolding-energy words through the valid/ready channels,
// predicts extension, best unfolded fraction, distance and minimum energy in
// fixed point, and compares every result word field by field. Covers zero
// force, saturating inputs and registers, a zero tolerance, a ratio below
// one, and random phases with random register settings and random idling.
// ----------------------------------------------------------------------------
module testbench;
	import cdem_pkg::*;

	localparam int          FB         = 32;
	localparam int          DIVS       = 19;
	localparam int          GRID       = 20;
	localparam logic [63:0] ONE        = 64'd1 << FB;
	localparam longint      CYCLE_CAP  = 200000000;
	localparam logic [31:0] STEP_FIRST = 32'd226050910;

	typedef struct packed {
		logic        [31:0] extension_ratio;
		logic        [32:0] unfolded_fraction;
		logic        [39:0] end_to_end_distance;
		logic signed [47:0] min_free_energy;
	} result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	cdem_in_if  in_ch();
	cdem_out_if out_ch();

	chain_domain_energy_minimizer uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
	);

	logic [39:0] folded_len_q;
	logic [39:0] ratio_q;
	logic [31:0] tolerance_q;
	result_t     expected_words[256];
	int          exp_wr = 0;
	int          exp_rd = 0;
	int          failures;
	bit          quiet;
	bit          started;
	longint      cycles = 0;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [63:0] mul_trunc(logic [63:0] a, logic [63:0] b, int s);
		logic [127:0] p;
		logic [63:0] r;
		p = {64'd0, a} * {64'd0, b};
		if ((p[127:64] >> s) != 0) return SAT;
		r = 64'(p >> s);
		return r > SAT ? SAT : r;
	endfunction

	function automatic logic [63:0] div_q(logic [63:0] a, logic [63:0] b);
		logic [127:0] q;
		if (b == 0 || (a >> (64 - FB)) >= b) return SAT;
		q = ({64'd0, a} << FB) / {64'd0, b};
		return q[63:0] > SAT ? SAT : q[63:0];
	endfunction

	function automatic logic [63:0] magnitude(longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic longint smul(longint a, longint b);
		logic [63:0] r;
		r = mul_trunc(magnitude(a), magnitude(b), FB);
		return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
	endfunction

	function automatic longint sat_add(longint a, longint b);
		longint s;
		s = longint'(SAT);
		if (a > s) a = s;
		if (a < -s) a = -s;
		if (b > s) b = s;
		if (b < -s) b = -s;
		if (a > 0 && b > s - a) return s;
		if (a < 0 && b < -s - a) return -s;
		return a + b;
	endfunction

	function automatic longint taylor(logic [63:0] th, bit want_sin);
		logic [63:0] th2, term, p;
		longint sum;
		th2 = mul_trunc(th, th, FB);
		term = want_sin ? th : ONE;
		p = want_sin ? 64'd1 : 64'd0;
		sum = longint'(term);
		for (int k = 0; k < 20 && term != 0; k++) begin
			term = mul_trunc(term, th2, FB) / ((p + 1) * (p + 2));
			p += 2;
			sum = (k & 1) ? sum + longint'(term) : sum - longint'(term);
		end
		return sum;
	endfunction

	function automatic longint cos_of_turns(logic [63:0] n);
		logic [63:0] t, q, th;
		t = n & (ONE - 1);
		q = (t >> (FB - 2)) & 64'd3;
		th = mul_trunc(t & ((ONE >> 2) - 1), TWO_PI_Q59, 59);
		case (q)
			64'd0: return taylor(th, 1'b0);
			64'd1: return -taylor(th, 1'b1);
			64'd2: return -taylor(th, 1'b0);
			default: return taylor(th, 1'b1);
		endcase
	endfunction

	function automatic logic [63:0] chain_force(logic [63:0] x);
		logic [63:0] inv, v;
		if (x >= (ONE * 99) / 100) return SAT;
		inv = div_q(ONE, ONE - x);
		v = mul_trunc(inv, inv, FB);
		if (v > SAT - 4 * x) return SAT;
		v = v - ONE + 4 * x;
		return v >> 2;
	endfunction

	function automatic longint domain_energy(logic [63:0] x, logic [63:0] n,
			logic [63:0] de, logic [63:0] f, logic [63:0] xi, longint dxi,
			output logic [63:0] len);
		longint l, wlc, u, work;
		logic [63:0] a, g;
		l = sat_add(longint'(xi), smul(longint'(n), dxi));
		len = l < 0 ? 64'd0 : 64'(l);
		if (x >= (ONE * 999) / 1000) begin
			wlc = longint'(SAT);
		end else begin
			a = mul_trunc(mul_trunc(x, x, FB), 3 * ONE - 2 * x, FB);
			g = div_q(a, ONE - x);
			wlc = longint'(mul_trunc(len, g, FB) >> 2);
		end
		u = sat_add(smul(longint'(de), longint'(n)), -smul(longint'(de), cos_of_turns(n)));
		work = longint'(mul_trunc(mul_trunc(f, x, FB), len, FB));
		return sat_add(sat_add(wlc, u), -work);
	endfunction

	function automatic result_t minimize(logic [39:0] force_in, logic [39:0] de_in);
		logic [63:0] f, de, xi, x, lo, hi, mid, step, nlo, nhi, best_n, n, len, tol, m;
		longint dxi, best_e, e;
		bit have;
		result_t r;
		f = 64'(force_in);
		de = 64'(de_in);
		xi = 64'(folded_len_q);
		dxi = longint'(mul_trunc(64'(ratio_q), xi, FB)) - longint'(xi);
		tol = 64'(tolerance_q);
		x = 0;
		if (f != 0) begin
			lo = 0;
			hi = ONE;
			for (int i = 0; i < 100 && hi - lo > 1; i++) begin
				mid = lo + (hi - lo) / 2;
				if (chain_force(mid) < f) lo = mid;
				else hi = mid;
			end
			x = lo + (hi - lo) / 2;
		end
		nlo = 0;
		nhi = ONE;
		best_n = 0;
		best_e = 0;
		have = 0;
		step = ONE / DIVS;
		forever begin
			for (int i = 0; i < GRID; i++) begin
				n = nlo + ((nhi - nlo) * i) / DIVS;
				e = domain_energy(x, n, de, f, xi, dxi, len);
				if (!have || e < best_e) begin
					have = 1;
					best_e = e;
					best_n = n;
				end
			end
			if (step <= tol) break;
			nlo = best_n > step ? best_n - step : 64'd0;
			nhi = best_n + step > ONE ? ONE : best_n + step;
			step = (nhi - nlo) / 10;
		end
		e = domain_energy(x, best_n, de, f, xi, dxi, len);
		r.extension_ratio = x > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : x[31:0];
		r.unfolded_fraction = best_n > ONE ? 33'(ONE) : best_n[32:0];
		m = mul_trunc(x, len, FB);
		r.end_to_end_distance = m > 64'hFF_FFFF_FFFF ? 40'hFF_FFFF_FFFF : m[39:0];
		if (best_e < 0) begin
			m = magnitude(best_e);
			if (m > (64'd1 << 47)) m = 64'd1 << 47;
			r.min_free_energy = 48'(-m);
		end else begin
			m = 64'(best_e);
			if (m > (64'd1 << 47) - 1) m = (64'd1 << 47) - 1;
			r.min_free_energy = m[47:0];
		end
		return r;
	endfunction

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.force_req = '0;
		in_ch.delta_e = '0;
		out_ch.ready = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("chain_domain_energy_minimizer: mismatch");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (started)
			out_ch.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 8);
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (exp_wr == exp_rd) begin
				$error("result word with no expectation");
				failures++;
			end else begin
				want = expected_words[exp_rd & 255];
				exp_rd++;
				if (out_ch.extension_ratio !== want.extension_ratio) begin
					$error("extension_ratio expected %0d got %0d",
						want.extension_ratio, out_ch.extension_ratio);
					failures++;
				end
				if (out_ch.unfolded_fraction !== want.unfolded_fraction) begin
					$error("unfolded_fraction expected %0d got %0d",
						want.unfolded_fraction, out_ch.unfolded_fraction);
					failures++;
				end
				if (out_ch.end_to_end_distance !== want.end_to_end_distance) begin
					$error("end_to_end_distance expected %0d got %0d",
						want.end_to_end_distance, out_ch.end_to_end_distance);
					failures++;
				end
				if (out_ch.min_free_energy !== want.min_free_energy) begin
					$error("min_free_energy expected %0d got %0d",
						want.min_free_energy, out_ch.min_free_energy);
					failures++;
				end
			end
		end
	end

	task automatic send_word(logic [39:0] force_in, logic [39:0] de_in);
		while (!quiet && $urandom_range(99) < 8) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.force_req <= force_in;
		in_ch.delta_e <= de_in;
		@(posedge clk);
		while (!(in_ch.valid && in_ch.ready)) @(posedge clk);
		expected_words[exp_wr & 255] = minimize(force_in, de_in);
		exp_wr++;
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (exp_wr != exp_rd) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_FOLDED_LENGTH: folded_len_q = value;
			REG_UNFOLD_RATIO: ratio_q = value;
			REG_STEP_TOLERANCE: tolerance_q = value[31:0];
			default: ;
		endcase
	endtask

	function automatic logic [39:0] rand40();
		return {8'($urandom), 32'($urandom)};
	endfunction

	function automatic logic [39:0] rand_force();
		case ($urandom_range(3))
			0: return rand40();
			1: return 40'd0;
			default: return 40'($urandom_range(32'hFFFF_FFFF)) * 40'($urandom_range(15));
		endcase
	endfunction

	task automatic test_defaults();
		send_word(40'd0, 40'd0);
		send_word(40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF);
		send_word(40'd1 << 32, 40'd1 << 32);
		send_word(40'd1, 40'd3 << 32);
		drain();
	endtask

	task automatic test_register_extremes();
		write_reg(REG_STEP_TOLERANCE, 40'hFF_FFFF_FFFF);
		send_word(40'd0, 40'hFF_FFFF_FFFF);
		send_word(40'hFF_FFFF_FFFF, 40'd0);
		send_word(40'd2 << 32, 40'd5 << 31);
		drain();
		write_reg(REG_FOLDED_LENGTH, 40'd0);
		write_reg(REG_UNFOLD_RATIO, 40'd0);
		send_word(40'd1 << 32, 40'd1 << 32);
		send_word(40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF);
		drain();
		write_reg(REG_FOLDED_LENGTH, 40'hFF_FFFF_FFFF);
		write_reg(REG_UNFOLD_RATIO, 40'hFF_FFFF_FFFF);
		send_word(40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF);
		send_word(40'd7 << 32, 40'd1 << 30);
		send_word(40'd0, 40'd0);
		drain();
		write_reg(REG_FOLDED_LENGTH, 40'd15461882266);
		write_reg(REG_UNFOLD_RATIO, 40'd1 << 31);
		send_word(40'd3 << 31, 40'd2 << 32);
		send_word(40'd1 << 35, 40'd1 << 28);
		drain();
		write_reg(REG_UNFOLD_RATIO, 40'd32641751450);
		write_reg(REG_STEP_TOLERANCE, 40'hAB_0000_0000);
		send_word(40'd1 << 32, 40'd2 << 32);
		drain();
	endtask

	task automatic test_random_phase(int count, bit hold_each, bit no_idle);
		write_reg(REG_FOLDED_LENGTH, $urandom_range(3) == 0 ? rand40() : 40'($urandom) << 2);
		write_reg(REG_UNFOLD_RATIO, $urandom_range(3) == 0 ? rand40() : 40'($urandom) << 3);
		write_reg(REG_STEP_TOLERANCE,
			{8'($urandom), 32'($urandom_range(32'hFFFF_FFFF, STEP_FIRST / 5))});
		quiet = no_idle;
		for (int i = 0; i < count; i++) begin
			send_word(rand_force(), $urandom_range(1) ? rand40() : 40'($urandom) << 1);
			if (hold_each) drain();
		end
		drain();
		quiet = 1'b0;
	endtask

	initial begin
		failures = 0;
		quiet = 1'b0;
		started = 1'b0;
		folded_len_q = FOLDED_LENGTH_RST;
		ratio_q = UNFOLD_RATIO_RST;
		tolerance_q = STEP_TOLERANCE_RST;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		started <= 1'b1;
		@(posedge clk);
		test_defaults();
		test_register_extremes();
		test_random_phase(25, 1'b0, 1'b0);
		test_random_phase(25, 1'b0, 1'b1);
		test_random_phase(15, 1'b1, 1'b0);
		test_random_phase(35, 1'b0, 1'b0);
		repeat (200) @(posedge clk);
		if (failures == 0 && exp_wr == exp_rd) begin
			$display("chain_domain_energy_minimizer: match");
		end else begin
			$display("chain_domain_energy_minimizer: mismatch");
		end
		$finish;
	end
endmodule
